// ===== hw/rtl/aabb_affine_transform_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the box transform core
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AABB_AFFINE_TRANSFORM_CORE_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define AAT_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AAT_ASSERT(label, clk, rst_n, ante, cons, msg)
`define AAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// Box transform package
// Widths, register indexes, reset values and shared types of the core.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int COORD_W   = 24;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 12;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int ROW_W     = 3 * COEF_W;

    localparam int PROD_W = COORD_W + COEF_W;
    localparam int BASE_W = COORD_W + COEF_FRAC;
    localparam int SUM_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = CFG_IDX_W'(5);

    localparam logic [CFG_W-1:0] ROW_X_RESET = CFG_W'(1) << COEF_FRAC;
    localparam logic [CFG_W-1:0] ROW_Y_RESET = CFG_W'(1) << (COEF_FRAC + COEF_W);
    localparam logic [CFG_W-1:0] ROW_Z_RESET = CFG_W'(1) << (COEF_FRAC + 2 * COEF_W);

    typedef struct packed {
        logic mul;
        logic sel;
        logic sum;
        logic out;
    } t_stage_en;

endpackage

// ===== hw/rtl/aabb_affine_transform_core.sv =====
// ----------------------------------------------------------------------------
// Axis-aligned box affine transform core
// A box request is accepted into an input register; a new box can be taken
// in every cycle, one per clock, while the output side does not stall, with
// all three row units working in parallel. Each row unit holds six 16 by 24
// bit multipliers, one per corner term, followed by a per-term min and max
// stage, an adder stage and a flooring and saturating output register. Each
// stage holds its request while the next stage is full and stalled, so stalls
// on the output side fill the pipeline before the input backs up. The user must
// write configuration only while no request is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
`include "aabb_affine_transform_core_macros.svh"

module aabb_affine_transform_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [aat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aat_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  aat_pkg::t_coord               i_lo_x,
    input  aat_pkg::t_coord               i_lo_y,
    input  aat_pkg::t_coord               i_lo_z,
    input  aat_pkg::t_coord               i_hi_x,
    input  aat_pkg::t_coord               i_hi_y,
    input  aat_pkg::t_coord               i_hi_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output aat_pkg::t_coord               o_new_lo_x,
    output aat_pkg::t_coord               o_new_lo_y,
    output aat_pkg::t_coord               o_new_lo_z,
    output aat_pkg::t_coord               o_new_hi_x,
    output aat_pkg::t_coord               o_new_hi_y,
    output aat_pkg::t_coord               o_new_hi_z,
    output logic                          o_clipped
);
    import aat_pkg::*;

    logic [CFG_W-1:0] r_row [3];
    t_coord           r_shift [3];
    t_coord           r_lo [3];
    t_coord           r_hi [3];
    logic [4:0]       r_valid;
    logic [5:0]       w_adv;
    t_stage_en        w_en;
    t_coord           w_out_lo [3];
    t_coord           w_out_hi [3];
    logic [2:0]       w_clip;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= ROW_X_RESET;
            r_row[1]   <= ROW_Y_RESET;
            r_row[2]   <= ROW_Z_RESET;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW_X:   r_row[0]   <= i_cfg_data;
                REG_ROW_Y:   r_row[1]   <= i_cfg_data;
                REG_ROW_Z:   r_row[2]   <= i_cfg_data;
                REG_SHIFT_X: r_shift[0] <= i_cfg_data[COORD_W-1:0];
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data[COORD_W-1:0];
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_adv[5] = i_out_ready;
        for (int k = 4; k >= 0; k--) begin
            w_adv[k] = !r_valid[k] || w_adv[k+1];
        end
    end

    assign o_in_ready = w_adv[0];
    assign w_en.mul   = w_adv[1];
    assign w_en.sel   = w_adv[2];
    assign w_en.sum   = w_adv[3];
    assign w_en.out   = w_adv[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_adv[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < 5; k++) begin
                if (w_adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_lo[0] <= i_lo_x;
            r_lo[1] <= i_lo_y;
            r_lo[2] <= i_lo_z;
            r_hi[0] <= i_hi_x;
            r_hi[1] <= i_hi_y;
            r_hi[2] <= i_hi_z;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_row
        aat_row u_row (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_row   (r_row[g]),
            .i_shift (r_shift[g]),
            .i_lo    (r_lo),
            .i_hi    (r_hi),
            .o_lo    (w_out_lo[g]),
            .o_hi    (w_out_hi[g]),
            .o_clip  (w_clip[g])
        );
    end

    assign o_out_valid = r_valid[4];
    assign o_new_lo_x  = w_out_lo[0];
    assign o_new_lo_y  = w_out_lo[1];
    assign o_new_lo_z  = w_out_lo[2];
    assign o_new_hi_x  = w_out_hi[0];
    assign o_new_hi_y  = w_out_hi[1];
    assign o_new_hi_z  = w_out_hi[2];
    assign o_clipped   = |w_clip;

    `AAT_ASSERT(a_box_ordered, i_clk, i_rst_n, o_out_valid,
        (o_new_lo_x <= o_new_hi_x) && (o_new_lo_y <= o_new_hi_y) &&
        (o_new_lo_z <= o_new_hi_z),
        "result box is not ordered")
    `AAT_ASSERT(a_clip_at_limit, i_clk, i_rst_n, o_out_valid && o_clipped,
        (o_new_lo_x == COORD_MAX) || (o_new_lo_x == COORD_MIN) ||
        (o_new_lo_y == COORD_MAX) || (o_new_lo_y == COORD_MIN) ||
        (o_new_lo_z == COORD_MAX) || (o_new_lo_z == COORD_MIN) ||
        (o_new_hi_x == COORD_MAX) || (o_new_hi_x == COORD_MIN) ||
        (o_new_hi_y == COORD_MAX) || (o_new_hi_y == COORD_MIN) ||
        (o_new_hi_z == COORD_MAX) || (o_new_hi_z == COORD_MIN),
        "clip flag without a saturated coordinate")
    `AAT_ASSERT(a_full_when_blocked, i_clk, i_rst_n, !o_in_ready, &r_valid,
        "input blocked while a stage is empty")
    `AAT_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_valid[0], "accepted request not held in the input stage")

endmodule

// ===== hw/rtl/aat_row.sv =====
// ----------------------------------------------------------------------------
// Box transform row unit
// Four-stage datapath for one output axis: products, per-term min and max,
// sums with the translation, then flooring and saturation.
// ----------------------------------------------------------------------------
module aat_row (
    input  logic                     i_clk,
    input  aat_pkg::t_stage_en       i_en,
    input  logic [aat_pkg::CFG_W-1:0] i_row,
    input  aat_pkg::t_coord          i_shift,
    input  aat_pkg::t_coord          i_lo [3],
    input  aat_pkg::t_coord          i_hi [3],
    output aat_pkg::t_coord          o_lo,
    output aat_pkg::t_coord          o_hi,
    output logic                     o_clip
);
    import aat_pkg::*;

    localparam t_sum SAT_MAX = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam t_sum SAT_MIN = ~SAT_MAX;

    logic [ROW_W-1:0] w_row;
    t_coef  w_coef [3];
    t_prod  r_prod_lo [3];
    t_prod  r_prod_hi [3];
    t_prod  r_min [3];
    t_prod  r_max [3];
    t_sum   w_base;
    t_sum   n_sum_min;
    t_sum   n_sum_max;
    t_sum   r_sum_min;
    t_sum   r_sum_max;
    t_sum   w_fl_min;
    t_sum   w_fl_max;
    t_coord n_lo;
    t_coord n_hi;
    logic   n_clip;
    t_coord r_lo;
    t_coord r_hi;
    logic   r_clip;

    assign w_row = ROW_W'(i_row);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_coef[k] = w_row[k*COEF_W +: COEF_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            for (int k = 0; k < 3; k++) begin
                r_prod_lo[k] <= w_coef[k] * i_lo[k];
                r_prod_hi[k] <= w_coef[k] * i_hi[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sel) begin
            for (int k = 0; k < 3; k++) begin
                if (r_prod_lo[k] < r_prod_hi[k]) begin
                    r_min[k] <= r_prod_lo[k];
                    r_max[k] <= r_prod_hi[k];
                end else begin
                    r_min[k] <= r_prod_hi[k];
                    r_max[k] <= r_prod_lo[k];
                end
            end
        end
    end

    always_comb begin
        w_base    = SUM_W'(i_shift) <<< COEF_FRAC;
        n_sum_min = w_base + SUM_W'(r_min[0]) + SUM_W'(r_min[1]) + SUM_W'(r_min[2]);
        n_sum_max = w_base + SUM_W'(r_max[0]) + SUM_W'(r_max[1]) + SUM_W'(r_max[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_sum_min <= n_sum_min;
            r_sum_max <= n_sum_max;
        end
    end

    // The arithmetic shift rounds towards minus infinity.
    always_comb begin
        w_fl_min = r_sum_min >>> COEF_FRAC;
        w_fl_max = r_sum_max >>> COEF_FRAC;
        n_clip   = 1'b0;
        if (w_fl_min > SAT_MAX) begin
            n_lo   = COORD_MAX;
            n_clip = 1'b1;
        end else if (w_fl_min < SAT_MIN) begin
            n_lo   = COORD_MIN;
            n_clip = 1'b1;
        end else begin
            n_lo = COORD_W'(w_fl_min);
        end
        if (w_fl_max > SAT_MAX) begin
            n_hi   = COORD_MAX;
            n_clip = 1'b1;
        end else if (w_fl_max < SAT_MIN) begin
            n_hi   = COORD_MIN;
            n_clip = 1'b1;
        end else begin
            n_hi = COORD_W'(w_fl_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.out) begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_clip <= n_clip;
        end
    end

    assign o_lo   = r_lo;
    assign o_hi   = r_hi;
    assign o_clip = r_clip;

endmodule

// ===== tb/sv/tb_aabb_affine_transform_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the axis-aligned box affine transform core
// Streams boxes through the core under several matrix and translation
// settings. Each transformed box is predicted from the extreme corner terms
// with 64-bit arithmetic, then floored and saturated. Every result is checked
// in order, with random stalls on both sides or none, and once the output holds
// off for a long stretch so that the pipeline fills and the input backs up.
// ----------------------------------------------------------------------------
module tb_aabb_affine_transform_core;
    import aat_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);
    localparam logic [COEF_W-1:0]    COEF_ONE     = COEF_W'(1) << COEF_FRAC;
    localparam logic [COEF_W-1:0]    COEF_TOP     = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]    COEF_BOT     = {1'b1, {(COEF_W-1){1'b0}}};
    localparam int                   DRAIN_CYCLES = 20;
    localparam int                   DRAIN_LIMIT  = 100000;
    localparam int                   PRINT_LIMIT  = 200;
    localparam int                   HOLD_CYCLES  = 300;
    localparam int                   TIMEOUT_NS   = 5000000;

    typedef logic [2:0][COORD_W-1:0] t_corner;
    typedef struct packed {
        t_corner lo;
        t_corner hi;
    } t_box;
    typedef struct packed {
        t_corner lo;
        t_corner hi;
        logic    clipped;
    } t_mapped_box;
    typedef struct packed {
        logic [2:0][CFG_W-1:0] rows;
        t_corner               shifts;
    } t_setting;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_coord               i_lo_x      = '0;
    t_coord               i_lo_y      = '0;
    t_coord               i_lo_z      = '0;
    t_coord               i_hi_x      = '0;
    t_coord               i_hi_y      = '0;
    t_coord               i_hi_z      = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_coord               o_new_lo_x;
    t_coord               o_new_lo_y;
    t_coord               o_new_lo_z;
    t_coord               o_new_hi_x;
    t_coord               o_new_hi_y;
    t_coord               o_new_hi_z;
    logic                 o_clipped;

    logic [CFG_W-1:0] row_coefs [3];
    t_coord           row_shift [3];
    t_mapped_box      expected_boxes [$];
    string            axis_name [3] = '{"x", "y", "z"};
    int               mismatches        = 0;
    int               src_idle_pct      = 0;
    int               sink_idle_pct     = 0;
    int               hold_cycles_left  = 0;

    aabb_affine_transform_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_lo_x      (i_lo_x),
        .i_lo_y      (i_lo_y),
        .i_lo_z      (i_lo_z),
        .i_hi_x      (i_hi_x),
        .i_hi_y      (i_hi_y),
        .i_hi_z      (i_hi_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_new_lo_x  (o_new_lo_x),
        .o_new_lo_y  (o_new_lo_y),
        .o_new_lo_z  (o_new_lo_z),
        .o_new_hi_x  (o_new_hi_x),
        .o_new_hi_y  (o_new_hi_y),
        .o_new_hi_z  (o_new_hi_z),
        .o_clipped   (o_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic longint coef_term(logic [CFG_W-1:0] row, int k);
        logic [COEF_W-1:0] raw;
        raw = row[k*COEF_W +: COEF_W];
        return longint'($signed(raw));
    endfunction

    // The top bit of the returned word is the saturation flag.
    function automatic logic [COORD_W:0] clamp_coord(longint v);
        if (v > longint'(COORD_MAX)) begin
            return {1'b1, COORD_MAX};
        end
        if (v < longint'(COORD_MIN)) begin
            return {1'b1, COORD_MIN};
        end
        return {1'b0, v[COORD_W-1:0]};
    endfunction

    // Each term takes its smaller and larger product on its own, which gives
    // the minimum and maximum over all eight corners.
    function automatic t_mapped_box map_box(t_box b);
        t_mapped_box      m;
        longint           lo_sum;
        longint           hi_sum;
        longint           c;
        longint           p;
        longint           q;
        logic [COORD_W:0] sat;
        int               r;
        int               k;
        m = '0;
        for (r = 0; r < 3; r++) begin
            lo_sum = longint'(row_shift[r]) <<< COEF_FRAC;
            hi_sum = lo_sum;
            for (k = 0; k < 3; k++) begin
                c = coef_term(row_coefs[r], k);
                p = c * longint'($signed(b.lo[k]));
                q = c * longint'($signed(b.hi[k]));
                if (p < q) begin
                    lo_sum += p;
                    hi_sum += q;
                end else begin
                    lo_sum += q;
                    hi_sum += p;
                end
            end
            sat = clamp_coord(lo_sum >>> COEF_FRAC);
            m.lo[r] = sat[COORD_W-1:0];
            m.clipped |= sat[COORD_W];
            sat = clamp_coord(hi_sum >>> COEF_FRAC);
            m.hi[r] = sat[COORD_W-1:0];
            m.clipped |= sat[COORD_W];
        end
        return m;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_mapped_box want;
        t_mapped_box got;
        int          k;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.lo = {o_new_lo_z, o_new_lo_y, o_new_lo_x};
            got.hi = {o_new_hi_z, o_new_hi_y, o_new_hi_x};
            got.clipped = o_clipped;
            if (expected_boxes.size() == 0) begin
                report_mismatch("result with no request outstanding", 0, 0);
            end else begin
                want = expected_boxes.pop_front();
                for (k = 0; k < 3; k++) begin
                    if (got.lo[k] !== want.lo[k]) begin
                        report_mismatch($sformatf("new_lo_%s", axis_name[k]),
                                        $signed(got.lo[k]), $signed(want.lo[k]));
                    end
                    if (got.hi[k] !== want.hi[k]) begin
                        report_mismatch($sformatf("new_hi_%s", axis_name[k]),
                                        $signed(got.hi[k]), $signed(want.hi[k]));
                    end
                end
                if (got.clipped !== want.clipped) begin
                    report_mismatch("clipped", got.clipped, want.clipped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles_left > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles_left = hold_cycles_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic send_box(t_box b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_lo_x <= b.lo[0];
        i_lo_y <= b.lo[1];
        i_lo_z <= b.lo[2];
        i_hi_x <= b.hi[0];
        i_hi_y <= b.hi[1];
        i_hi_z <= b.hi[2];
        do @(posedge i_clk); while (!o_in_ready);
        expected_boxes.push_back(map_box(b));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
    endtask

    // Leaves the request valid raised; the caller lowers it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ROW_X:   row_coefs[0] = data;
            REG_ROW_Y:   row_coefs[1] = data;
            REG_ROW_Z:   row_coefs[2] = data;
            REG_SHIFT_X: row_shift[0] = data[COORD_W-1:0];
            REG_SHIFT_Y: row_shift[1] = data[COORD_W-1:0];
            REG_SHIFT_Z: row_shift[2] = data[COORD_W-1:0];
            default:     ;
        endcase
    endtask

    function automatic logic [CFG_W-1:0] shift_word(logic [COORD_W-1:0] s);
        logic [CFG_W-1:0] w;
        w = CFG_W'({$urandom, $urandom});
        w[COORD_W-1:0] = s;
        return w;
    endfunction

    task automatic load_setting(t_setting s, bit poke_spare);
        wait_drained();
        if (poke_spare) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      CFG_W'({$urandom, $urandom}));
        end
        write_reg(REG_ROW_X, s.rows[0]);
        write_reg(REG_ROW_Y, s.rows[1]);
        write_reg(REG_ROW_Z, s.rows[2]);
        write_reg(REG_SHIFT_X, shift_word(s.shifts[0]));
        write_reg(REG_SHIFT_Y, shift_word(s.shifts[1]));
        write_reg(REG_SHIFT_Z, shift_word(s.shifts[2]));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pack_row(logic [COEF_W-1:0] cx, logic [COEF_W-1:0] cy,
                                                  logic [COEF_W-1:0] cz);
        return {cz, cy, cx};
    endfunction

    function automatic t_box make_box(int lx, int ly, int lz, int hx, int hy, int hz);
        t_box b;
        b.lo = {COORD_W'(lz), COORD_W'(ly), COORD_W'(lx)};
        b.hi = {COORD_W'(hz), COORD_W'(hy), COORD_W'(hx)};
        return b;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0, 1:    return COEF_W'($urandom);
            2, 3, 4: return COEF_W'($urandom_range(0, 2 * COEF_ONE) - COEF_ONE);
            5:       return '0;
            6:       return COEF_ONE;
            default: return $urandom_range(0, 1) ? COEF_TOP : COEF_BOT;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_W'($urandom);
            1:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            2, 3:    return COORD_W'($urandom_range(0, 1 << 17) - (1 << 16));
            default: return COORD_W'($urandom_range(0, 1 << 21) - (1 << 20));
        endcase
    endfunction

    // Mostly ordered boxes; about one in eight keeps whatever order it drew.
    function automatic t_box rand_box();
        t_box             b;
        logic [COORD_W-1:0] swap;
        int               k;
        for (k = 0; k < 3; k++) begin
            b.lo[k] = rand_coord();
            b.hi[k] = rand_coord();
        end
        if ($urandom_range(0, 7) != 0) begin
            for (k = 0; k < 3; k++) begin
                if ($signed(b.lo[k]) > $signed(b.hi[k])) begin
                    swap = b.lo[k];
                    b.lo[k] = b.hi[k];
                    b.hi[k] = swap;
                end
            end
        end
        return b;
    endfunction

    function automatic t_setting rand_setting();
        t_setting s;
        int       r;
        for (r = 0; r < 3; r++) begin
            s.rows[r] = pack_row(rand_coef(), rand_coef(), rand_coef());
            s.shifts[r] = rand_coord();
        end
        return s;
    endfunction

    task automatic test_reset_identity();
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(make_box(-1, 255, -256, 1, 256, 257));
    endtask

    task automatic test_extreme_settings();
        t_setting s;
        s.rows = {3{pack_row(COEF_TOP, COEF_TOP, COEF_TOP)}};
        s.shifts = {3{COORD_MAX}};
        load_setting(s, 1'b0);
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(-512, -512, -512, -256, -256, -256));
        s.rows = {3{pack_row(COEF_BOT, COEF_BOT, COEF_BOT)}};
        s.shifts = {3{COORD_MIN}};
        load_setting(s, 1'b0);
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(-512, -512, -512, -256, -256, -256));
    endtask

    task automatic test_flooring();
        t_setting s;
        s.rows[0] = pack_row(COEF_W'(-1), COEF_ONE, '0);
        s.rows[1] = pack_row(-COEF_ONE, '0, COEF_W'(3));
        s.rows[2] = pack_row(COEF_W'(2048), COEF_W'(-2048), COEF_ONE);
        s.shifts = {COORD_W'(-129), COORD_W'(1), COORD_W'(-1)};
        load_setting(s, 1'b1);
        send_box(make_box(1, 1, 1, 3, 5, 7));
        send_box(make_box(-7, -1, -255, 7, 1, 255));
        send_box(make_box(5, -3, 2, -5, 3, -2));
        send_box(make_box(0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_stream(int n_settings, int per_setting, int src_pct, int sink_pct);
        int i;
        int j;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (i = 0; i < n_settings; i++) begin
            load_setting(rand_setting(), $urandom_range(0, 2) == 0);
            for (j = 0; j < per_setting; j++) begin
                send_box(rand_box());
            end
        end
    endtask

    task automatic test_output_hold();
        int j;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        load_setting(rand_setting(), 1'b0);
        hold_cycles_left = HOLD_CYCLES;
        for (j = 0; j < 60; j++) begin
            send_box(rand_box());
        end
    endtask

    initial begin
        int guard;
        row_coefs[0] = ROW_X_RESET;
        row_coefs[1] = ROW_Y_RESET;
        row_coefs[2] = ROW_Z_RESET;
        row_shift[0] = '0;
        row_shift[1] = '0;
        row_shift[2] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 19;
        sink_idle_pct = 62;
        test_reset_identity();
        test_extreme_settings();
        test_flooring();
        test_random_stream(3, 140, 19, 62);
        test_random_stream(3, 140, 62, 19);
        test_random_stream(3, 140, 0, 0);
        test_output_hold();

        i_in_valid <= 1'b0;
        guard = 0;
        while (expected_boxes.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_boxes.size() != 0) begin
            report_mismatch("results still outstanding", expected_boxes.size(), 0);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/aat_pkg.sv
hw/rtl/aat_row.sv
hw/rtl/aabb_affine_transform_core.sv
tb/sv/tb_aabb_affine_transform_core.sv
